[src/quote_aware_field_splitter_unit_assert.svh]
`ifndef QUOTE_AWARE_FIELD_SPLITTER_UNIT_ASSERT_SVH
`define QUOTE_AWARE_FIELD_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication
`define QAFS_ASSERT_NOW(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("qafs assertion failed");

// next-cycle implication
`define QAFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("qafs assertion failed");

`endif

[src/qafs_pkg.sv]
`timescale 1ns / 1ps
package qafs_pkg;

	localparam int DELIM_MAX_DEF     = 8;
	localparam int POSITION_BITS_DEF = 16;
	localparam int FIELD_W           = 16;
	localparam int DLEN_W            = 4;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_ADDR_W        = 5;
	localparam int FIFO_DEPTH        = 4;
	localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH) + 1;

	localparam logic [FIELD_W-1:0] INDEX_MAX = {FIELD_W{1'b1}};

	localparam logic [1:0] REG_DELIM_BYTES  = 2'd0;
	localparam logic [1:0] REG_DELIM_LENGTH = 2'd1;
	localparam logic [1:0] REG_QUOTE_CHAR   = 2'd2;
	localparam logic [1:0] REG_IGNORE_EMPTY = 2'd3;

	localparam logic [63:0]       RST_DELIM_BYTES  = 64'd44;
	localparam logic [DLEN_W-1:0] RST_DELIM_LENGTH = 4'd1;
	localparam logic [7:0]        RST_QUOTE_CHAR   = 8'd34;

	typedef struct packed {
		logic [63:0]       delimiter_bytes;
		logic [DLEN_W-1:0] delimiter_length;
		logic [7:0]        quote_char;
		logic              ignore_empty;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] field_start;
		logic [FIELD_W-1:0] field_length;
		logic [FIELD_W-1:0] field_index;
		logic               field_last;
		logic               overflow;
	} result_t;

endpackage

[src/qafs_in_if.sv]
`timescale 1ns / 1ps
interface qafs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[src/qafs_out_if.sv]
`timescale 1ns / 1ps
interface qafs_out_if;
	import qafs_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] field_start;
	logic [FIELD_W-1:0] field_length;
	logic [FIELD_W-1:0] field_index;
	logic               field_last;
	logic               overflow;

	modport source (output valid, output field_start, output field_length,
		output field_index, output field_last, output overflow, input ready);
	modport sink (input valid, input field_start, input field_length,
		input field_index, input field_last, input overflow, output ready);
endinterface

[src/quote_aware_field_splitter_unit.sv]
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// in_ch     in   valid/ready   data_byte, last_byte
// out_ch    out  valid/ready   field_start, field_length, field_index, field_last, overflow
// cfg       in   APB rd/wr     delimiter_bytes, delimiter_length, quote_char, ignore_empty
//
// One byte per cycle; the delimiter compare, quote toggle and field math finish in the
// cycle a byte is taken and the fields land in a four-entry result queue.
// A byte that both ends a field at a delimiter and closes the string gives two fields,
// which leave one per cycle; in_ch.ready drops while fewer than two queue slots are free.
// arst_n clears the string state and the queue and loads register defaults.
module quote_aware_field_splitter_unit #(
	parameter int DELIM_MAX     = qafs_pkg::DELIM_MAX_DEF,
	parameter int POSITION_BITS = qafs_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [qafs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [qafs_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [qafs_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	qafs_in_if.sink                         in_ch,
	qafs_out_if.source                      out_ch
);
	import qafs_pkg::*;

	cfg_t    cfg;
	result_t res_a;
	result_t res_b;
	result_t head;
	logic    res_a_vld;
	logic    res_b_vld;
	logic    room;
	logic    in_fire;

	assign in_ch.ready = room;
	assign in_fire     = in_ch.valid & room;

	qafs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qafs_core #(
		.DELIM_MAX     (DELIM_MAX),
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_fire   (in_fire),
		.data_byte (in_ch.data_byte),
		.last_byte (in_ch.last_byte),
		.res_a     (res_a),
		.res_a_vld (res_a_vld),
		.res_b     (res_b),
		.res_b_vld (res_b_vld)
	);

	qafs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_a     (res_a),
		.push_a_vld (res_a_vld & in_fire),
		.push_b     (res_b),
		.push_b_vld (res_b_vld & in_fire),
		.room       (room),
		.head       (head),
		.head_vld   (out_ch.valid),
		.head_rdy   (out_ch.ready)
	);

	assign out_ch.field_start  = head.field_start;
	assign out_ch.field_length = head.field_length;
	assign out_ch.field_index  = head.field_index;
	assign out_ch.field_last   = head.field_last;
	assign out_ch.overflow     = head.overflow;
endmodule

[src/qafs_cfg.sv]
`timescale 1ns / 1ps
module qafs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [qafs_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [qafs_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [qafs_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	output qafs_pkg::cfg_t                   cfg
);
	import qafs_pkg::*;

	logic [1:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_bytes  <= RST_DELIM_BYTES;
			cfg_q.delimiter_length <= RST_DELIM_LENGTH;
			cfg_q.quote_char       <= RST_QUOTE_CHAR;
			cfg_q.ignore_empty     <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DELIM_BYTES: begin
					cfg_q.delimiter_bytes <= pwdata[63:0];
				end
				REG_DELIM_LENGTH: begin
					cfg_q.delimiter_length <= pwdata[DLEN_W-1:0];
				end
				REG_QUOTE_CHAR: begin
					cfg_q.quote_char <= pwdata[7:0];
				end
				REG_IGNORE_EMPTY: begin
					cfg_q.ignore_empty <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DELIM_BYTES:  prdata = cfg_q.delimiter_bytes;
			REG_DELIM_LENGTH: prdata = CFG_DATA_W'(cfg_q.delimiter_length);
			REG_QUOTE_CHAR:   prdata = CFG_DATA_W'(cfg_q.quote_char);
			REG_IGNORE_EMPTY: prdata = CFG_DATA_W'(cfg_q.ignore_empty);
			default:          prdata = '0;
		endcase
	end
endmodule

[src/qafs_core.sv]
`timescale 1ns / 1ps
module qafs_core #(
	parameter int DELIM_MAX     = qafs_pkg::DELIM_MAX_DEF,
	parameter int POSITION_BITS = qafs_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qafs_pkg::cfg_t    cfg,
	input  logic              in_fire,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output qafs_pkg::result_t res_a,
	output logic              res_a_vld,
	output qafs_pkg::result_t res_b,
	output logic              res_b_vld
);
	import qafs_pkg::*;

	localparam int POS_W = POSITION_BITS;
	localparam int IDX_W = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	logic [7:0]         win_q [DELIM_MAX];
	logic [7:0]         win_n [DELIM_MAX];
	logic               in_quote_q;
	logic               in_quote_n;
	logic [IDX_W-1:0]   skip_q;
	logic [IDX_W-1:0]   skip_n;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   pos_n;
	logic [POS_W-1:0]   cur_q;
	logic [POS_W-1:0]   cur_n;
	logic [FIELD_W-1:0] fr_q;
	logic [FIELD_W-1:0] fr_mid;
	logic [FIELD_W-1:0] fr_n;
	logic               ovf_q;
	logic               ovf_n;

	logic [DLEN_W-1:0]  ll;
	logic [DLEN_W-1:0]  llm1;
	logic               ovf_hit;
	logic [POS_W-1:0]   s_pos;
	logic [POS_W:0]     ns_pos;
	logic [POS_W-1:0]   len_end;
	logic [POS_W-1:0]   len_a;
	logic [POS_W-1:0]   len_b;
	logic [POS_W+FIELD_W-1:0] ext_start_a;
	logic [POS_W+FIELD_W-1:0] ext_len_a;
	logic [POS_W+FIELD_W-1:0] ext_start_b;
	logic [POS_W+FIELD_W-1:0] ext_len_b;
	logic [7:0]         tap;
	logic               quoted;
	logic               match;
	logic               hit;

	always_comb begin
		win_n[0] = data_byte;
		for (int k = 1; k < DELIM_MAX; k++) begin
			win_n[k] = win_q[k-1];
		end
	end

	always_comb begin
		if (cfg.delimiter_length == '0) begin
			ll = DLEN_W'(1);
		end else if (cfg.delimiter_length > DLEN_W'(DELIM_MAX)) begin
			ll = DLEN_W'(DELIM_MAX);
		end else begin
			ll = cfg.delimiter_length;
		end
	end

	assign llm1    = ll - DLEN_W'(1);
	assign ovf_hit = (pos_q == POS_MAX);
	assign ovf_n   = ovf_q | ovf_hit;
	assign pos_n   = ovf_hit ? pos_q : pos_q + POS_W'(1);
	assign s_pos   = pos_q - POS_W'(llm1);
	assign ns_pos  = {1'b0, s_pos} + (POS_W+1)'(ll);
	assign len_end = ovf_hit ? POS_MAX : pos_q + POS_W'(1);
	assign tap     = win_n[llm1[IDX_W-1:0]];

	always_comb begin
		logic [DLEN_W-1:0] idx;
		idx   = '0;
		match = 1'b1;
		for (int j = 0; j < DELIM_MAX; j++) begin
			if (DLEN_W'(j) < ll) begin
				idx = llm1 - DLEN_W'(j);
				if (win_n[idx[IDX_W-1:0]] != cfg.delimiter_bytes[8*j +: 8]) begin
					match = 1'b0;
				end
			end
		end
	end

	always_comb begin
		in_quote_n = in_quote_q;
		skip_n     = skip_q;
		quoted     = 1'b0;
		hit        = 1'b0;
		if (pos_q >= POS_W'(llm1)) begin
			if (skip_q != '0) begin
				skip_n = skip_q - IDX_W'(1);
			end else begin
				if (cfg.quote_char != 8'd0) begin
					if (in_quote_q) begin
						if (tap == cfg.quote_char) begin
							in_quote_n = 1'b0;
						end
						quoted = 1'b1;
					end else if (tap == cfg.quote_char) begin
						in_quote_n = 1'b1;
						quoted     = 1'b1;
					end
				end
				if (!quoted && match) begin
					hit    = 1'b1;
					skip_n = llm1[IDX_W-1:0];
				end
			end
		end
	end

	always_comb begin
		cur_n = cur_q;
		if (hit) begin
			cur_n = (ns_pos > {1'b0, POS_MAX}) ? POS_MAX : ns_pos[POS_W-1:0];
		end
	end

	assign len_a = (s_pos > cur_q) ? s_pos - cur_q : '0;
	assign len_b = (len_end > cur_n) ? len_end - cur_n : '0;

	assign res_a_vld = hit && !(cfg.ignore_empty && len_a == '0);
	assign res_b_vld = last_byte && !(cfg.ignore_empty && len_b == '0);

	assign fr_mid = (res_a_vld && fr_q != INDEX_MAX) ? fr_q + FIELD_W'(1) : fr_q;
	assign fr_n   = (res_b_vld && fr_mid != INDEX_MAX) ? fr_mid + FIELD_W'(1) : fr_mid;

	assign ext_start_a = {{FIELD_W{1'b0}}, cur_q};
	assign ext_len_a   = {{FIELD_W{1'b0}}, len_a};
	assign ext_start_b = {{FIELD_W{1'b0}}, cur_n};
	assign ext_len_b   = {{FIELD_W{1'b0}}, len_b};

	always_comb begin
		res_a.field_start  = ext_start_a[FIELD_W-1:0];
		res_a.field_length = ext_len_a[FIELD_W-1:0];
		res_a.field_index  = fr_q;
		res_a.field_last   = 1'b0;
		res_a.overflow     = ovf_n;
		res_b.field_start  = ext_start_b[FIELD_W-1:0];
		res_b.field_length = ext_len_b[FIELD_W-1:0];
		res_b.field_index  = fr_mid;
		res_b.field_last   = 1'b1;
		res_b.overflow     = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DELIM_MAX; k++) begin
				win_q[k] <= 8'd0;
			end
			in_quote_q <= 1'b0;
			skip_q     <= '0;
			pos_q      <= '0;
			cur_q      <= '0;
			fr_q       <= '0;
			ovf_q      <= 1'b0;
		end else if (in_fire) begin
			if (last_byte) begin
				for (int k = 0; k < DELIM_MAX; k++) begin
					win_q[k] <= 8'd0;
				end
				in_quote_q <= 1'b0;
				skip_q     <= '0;
				pos_q      <= '0;
				cur_q      <= '0;
				fr_q       <= '0;
				ovf_q      <= 1'b0;
			end else begin
				for (int k = 0; k < DELIM_MAX; k++) begin
					win_q[k] <= win_n[k];
				end
				in_quote_q <= in_quote_n;
				skip_q     <= skip_n;
				pos_q      <= pos_n;
				cur_q      <= cur_n;
				fr_q       <= fr_n;
				ovf_q      <= ovf_n;
			end
		end
	end
endmodule

[src/qafs_fifo.sv]
`timescale 1ns / 1ps
module qafs_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  qafs_pkg::result_t push_a,
	input  logic              push_a_vld,
	input  qafs_pkg::result_t push_b,
	input  logic              push_b_vld,
	output logic              room,
	output qafs_pkg::result_t head,
	output logic              head_vld,
	input  logic              head_rdy
);
	import qafs_pkg::*;

	result_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wp_q;
	logic [FIFO_PTR_W-1:0]   rp_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;
	logic [FIFO_CNT_W-1:0]   n_push;
	logic                    pop;
	result_t                 first;

	assign room     = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rp_q];
	assign pop      = head_vld & head_rdy;
	assign first    = push_a_vld ? push_a : push_b;
	assign n_push   = FIFO_CNT_W'(push_a_vld) + FIFO_CNT_W'(push_b_vld);

	always_ff @(posedge clk) begin
		if (push_a_vld | push_b_vld) begin
			mem_q[wp_q] <= first;
		end
		if (push_a_vld & push_b_vld) begin
			mem_q[wp_q + FIFO_PTR_W'(1)] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[FIFO_PTR_W-1:0];
			rp_q  <= rp_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + n_push - FIFO_CNT_W'(pop);
		end
	end
endmodule

[src/qafs_checker.sv]
`timescale 1ns / 1ps
`include "quote_aware_field_splitter_unit_assert.svh"
module qafs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [qafs_pkg::FIELD_W-1:0] out_field_start,
	input logic [qafs_pkg::FIELD_W-1:0] out_field_length,
	input logic [qafs_pkg::FIELD_W-1:0] out_field_index,
	input logic                         out_field_last
);
	import qafs_pkg::*;

	logic                   new_string_q;
	logic [3*FIELD_W:0]     out_payload;

	assign out_payload = {out_field_start, out_field_length, out_field_index, out_field_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_string_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			new_string_q <= out_field_last;
		end
	end

	`QAFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`QAFS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_payload))
	`QAFS_ASSERT_NOW(a_stall_has_data, clk, arst_n, !in_ready, out_valid)
	`QAFS_ASSERT_NOW(a_index_restart, clk, arst_n, new_string_q && out_valid, out_field_index == '0)
endmodule

bind quote_aware_field_splitter_unit qafs_checker u_qafs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_field_start  (out_ch.field_start),
	.out_field_length (out_ch.field_length),
	.out_field_index  (out_ch.field_index),
	.out_field_last   (out_ch.field_last)
);
